@@ hdl/vle_ring_pkg.sv @@
// Shared types and constants for the variable-length event ring.
// No dependencies; used by variable_length_event_ring.
package vle_ring_pkg;

  localparam int RING_SIZE_DEF   = 256;
  localparam int MAX_PAYLOAD_DEF = 8;
  localparam int MAX_EVENTS_DEF  = 8;

  // Action codes carried in an input word.
  localparam logic ACT_POST = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  // Config register indexes.
  localparam logic CFG_EVENT_SIZES = 1'b0;
  localparam logic CFG_EVENT_COUNT = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_BAD   = 2'd2,
    STAT_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POST,
    ST_POP_IDX,
    ST_POP_DAT
  } state_t;

  typedef struct packed {
    logic        action;
    logic [7:0]  event_index;
    logic [63:0] payload;
  } in_word_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  out_index;
    logic [3:0]  out_size;
    logic [63:0] out_payload;
    logic [7:0]  min_free;
  } out_word_t;

endpackage

@@ hdl/variable_length_event_ring.sv @@
// Variable-length event record ring: byte-wide ring memory plus post/pop sequencer.
// Depends on vle_ring_pkg (types, codes, parameter defaults).
//
// Usage: drive in_word and raise start while busy is low; the word is taken at
// that edge. Exactly one result word follows on out_word, flagged by out_strobe
// for a single cycle; there is no backpressure, so capture it when it appears.
// Every step goes through a single byte-wide synchronous RAM, one byte per
// cycle. A post that is written stores the index byte and then its payload
// bytes before the output register is set; a rejected post or an empty pop
// is answered from the output register alone. A pop reads the index byte
// (ST_POP_IDX), then up to MAX_PAYLOAD payload bytes (ST_POP_DAT). busy drops
// in the cycle the result strobes, so the next word can be issued then.
// Config writes (cfg_we, cfg_index, cfg_data) land at once and must only be
// issued while busy is low. The ring RAM is not cleared at reset; pops only
// ever read bytes between the pointers, which have been written.
module variable_length_event_ring #(
  parameter int RING_SIZE   = vle_ring_pkg::RING_SIZE_DEF,
  parameter int MAX_PAYLOAD = vle_ring_pkg::MAX_PAYLOAD_DEF,
  parameter int MAX_EVENTS  = vle_ring_pkg::MAX_EVENTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  vle_ring_pkg::in_word_t  in_word,
  output logic                   out_strobe,
  output vle_ring_pkg::out_word_t out_word,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [31:0]            cfg_data
);

  localparam int PW = $clog2(RING_SIZE);
  localparam int MW = (PW > 8) ? PW : 8;
  localparam logic [PW:0]   RS_EXT   = (PW+1)'(RING_SIZE);
  localparam logic [PW-1:0] RS_LAST  = PW'(RING_SIZE - 1);
  localparam logic [3:0]    MAXP     = 4'(MAX_PAYLOAD);
  localparam logic [3:0]    MAXE     = 4'(MAX_EVENTS);

  // Ring storage
  logic [7:0] mem [RING_SIZE];
  logic          mem_we;
  logic [PW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [7:0]    rd_data_r;

  // Control and datapath registers
  vle_ring_pkg::state_t    state_r, state_nxt;
  vle_ring_pkg::in_word_t  item_r, item_nxt;
  vle_ring_pkg::out_word_t out_word_r, out_word_nxt;
  logic          out_strobe_r, out_strobe_nxt;
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [PW-1:0] mark_r, mark_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic [3:0]    len_r, len_nxt;
  logic [63:0]   acc_r, acc_nxt;
  logic [31:0]   sizes_r;
  logic [3:0]    count_r;

  function automatic logic idx_valid(logic [7:0] idx, logic [3:0] cnt);
    logic [3:0] n;
    n = (cnt > MAXE) ? MAXE : cnt;
    return (idx != 8'd0) && ({4'd0, n} >= idx);
  endfunction

  function automatic logic [3:0] size_of(logic [7:0] idx, logic [31:0] sizes);
    logic [7:0] km;
    logic [2:0] k;
    logic [3:0] s;
    km = idx - 8'd1;
    k  = km[2:0];
    s  = sizes[{k, 2'b00} +: 4];
    return (s > MAXP) ? MAXP : s;
  endfunction

  function automatic logic [PW-1:0] bump(logic [PW-1:0] p);
    return (p == RS_LAST) ? '0 : p + 1'b1;
  endfunction

  // Bytes in use, (wp - rp) mod RING_SIZE
  function automatic logic [PW-1:0] used_of(logic [PW-1:0] wp, logic [PW-1:0] rp);
    logic [PW:0] d;
    if (wp >= rp) begin
      d = {1'b0, wp} - {1'b0, rp};
    end else begin
      d = {1'b0, wp} + RS_EXT - {1'b0, rp};
    end
    return d[PW-1:0];
  endfunction

  function automatic vle_ring_pkg::out_word_t mk_result(
    vle_ring_pkg::status_t st, logic [7:0] idx, logic [3:0] sz,
    logic [63:0] pay, logic [PW-1:0] mark);
    vle_ring_pkg::out_word_t r;
    logic [MW-1:0] m;
    m = MW'(mark);
    r.status      = st;
    r.out_index   = idx;
    r.out_size    = sz;
    r.out_payload = pay;
    r.min_free    = (m > MW'(255)) ? 8'hFF : m[7:0];
    return r;
  endfunction

  // Next-state logic
  always_comb begin
    logic [3:0]    sz;
    logic [PW-1:0] used;
    logic [PW-1:0] avail;
    logic [PW-1:0] need;
    logic [PW-1:0] left;
    logic [3:0]    bsel;
    logic [7:0]    b;

    state_nxt      = state_r;
    item_nxt       = item_r;
    out_word_nxt   = out_word_r;
    out_strobe_nxt = 1'b0;
    wp_nxt         = wp_r;
    rp_nxt         = rp_r;
    mark_nxt       = mark_r;
    cnt_nxt        = cnt_r;
    len_nxt        = len_r;
    acc_nxt        = acc_r;
    mem_we         = 1'b0;
    mem_waddr      = wp_r;
    mem_wdata      = 8'd0;

    sz    = 4'd0;
    used  = used_of(wp_r, rp_r);
    avail = RS_LAST - used;
    need  = '0;
    left  = '0;
    bsel  = cnt_r - 4'd1;
    b     = rd_data_r;

    case (state_r)
      vle_ring_pkg::ST_IDLE: begin
        if (start) begin
          item_nxt = in_word;
          if (in_word.action == vle_ring_pkg::ACT_POST) begin
            if (!idx_valid(in_word.event_index, count_r)) begin
              out_word_nxt   = mk_result(vle_ring_pkg::STAT_BAD, 8'd0, 4'd0, 64'd0, mark_r);
              out_strobe_nxt = 1'b1;
            end else begin
              sz   = size_of(in_word.event_index, sizes_r);
              need = PW'(sz) + 1'b1;
              if (avail < need) begin
                out_word_nxt   = mk_result(vle_ring_pkg::STAT_FULL, 8'd0, 4'd0, 64'd0,
                                           mark_r);
                out_strobe_nxt = 1'b1;
              end else begin
                left = avail - need;
                if (left < mark_r) begin
                  mark_nxt = left;
                end
                len_nxt   = sz;
                cnt_nxt   = 4'd0;
                state_nxt = vle_ring_pkg::ST_POST;
              end
            end
          end else begin
            if (wp_r == rp_r) begin
              out_word_nxt   = mk_result(vle_ring_pkg::STAT_EMPTY, 8'd0, 4'd0, 64'd0, mark_r);
              out_strobe_nxt = 1'b1;
            end else begin
              // RAM reads rp_r at this edge; index byte lands in rd_data_r
              rp_nxt    = bump(rp_r);
              state_nxt = vle_ring_pkg::ST_POP_IDX;
            end
          end
        end
      end

      vle_ring_pkg::ST_POST: begin
        mem_we    = 1'b1;
        mem_wdata = (cnt_r == 4'd0) ? item_r.event_index
                                    : item_r.payload[{bsel[2:0], 3'b000} +: 8];
        wp_nxt    = bump(wp_r);
        cnt_nxt   = cnt_r + 4'd1;
        if (cnt_r == len_r) begin
          out_word_nxt   = mk_result(vle_ring_pkg::STAT_OK, 8'd0, 4'd0, 64'd0, mark_r);
          out_strobe_nxt = 1'b1;
          state_nxt      = vle_ring_pkg::ST_IDLE;
        end
      end

      vle_ring_pkg::ST_POP_IDX: begin
        if (!idx_valid(b, count_r)) begin
          out_word_nxt   = mk_result(vle_ring_pkg::STAT_BAD, b, 4'd0, 64'd0, mark_r);
          out_strobe_nxt = 1'b1;
          state_nxt      = vle_ring_pkg::ST_IDLE;
        end else begin
          sz = size_of(b, sizes_r);
          // clamp to what is still stored
          if (used < PW'(sz)) begin
            sz = used[3:0];
          end
          if (sz == 4'd0) begin
            out_word_nxt   = mk_result(vle_ring_pkg::STAT_OK, b, 4'd0, 64'd0, mark_r);
            out_strobe_nxt = 1'b1;
            state_nxt      = vle_ring_pkg::ST_IDLE;
          end else begin
            item_nxt.event_index = b;
            len_nxt   = sz;
            cnt_nxt   = 4'd0;
            acc_nxt   = 64'd0;
            rp_nxt    = bump(rp_r);
            state_nxt = vle_ring_pkg::ST_POP_DAT;
          end
        end
      end

      vle_ring_pkg::ST_POP_DAT: begin
        acc_nxt[{cnt_r[2:0], 3'b000} +: 8] = b;
        if (cnt_r + 4'd1 == len_r) begin
          out_word_nxt   = mk_result(vle_ring_pkg::STAT_OK, item_r.event_index, len_r,
                                     acc_nxt, mark_r);
          out_strobe_nxt = 1'b1;
          state_nxt      = vle_ring_pkg::ST_IDLE;
        end else begin
          rp_nxt  = bump(rp_r);
          cnt_nxt = cnt_r + 4'd1;
        end
      end

      default: begin
        state_nxt = vle_ring_pkg::ST_IDLE;
      end
    endcase
  end

  // Ring RAM: one write port, registered read at the read pointer
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rp_r];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= vle_ring_pkg::ST_IDLE;
      out_strobe_r <= 1'b0;
      wp_r         <= '0;
      rp_r         <= '0;
      mark_r       <= RS_LAST;
      sizes_r      <= 32'd0;
      count_r      <= 4'd0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      wp_r         <= wp_nxt;
      rp_r         <= rp_nxt;
      mark_r       <= mark_nxt;
      if (cfg_we) begin
        case (cfg_index)
          vle_ring_pkg::CFG_EVENT_SIZES: sizes_r <= cfg_data;
          vle_ring_pkg::CFG_EVENT_COUNT: count_r <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_word_r <= out_word_nxt;
    cnt_r      <= cnt_nxt;
    len_r      <= len_nxt;
    acc_r      <= acc_nxt;
  end

  assign busy       = (state_r != vle_ring_pkg::ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule
